/* sv/awna_pkg.sv */
// awna_pkg: widths, register codes and stage types for the affine warp
// nearest-neighbor address block. No dependencies.
package awna_pkg;

  localparam int MaxDim  = 4096;
  localparam int CoordW  = 12;
  localparam int SpanW   = 13;
  localparam int CoefW   = 32;
  localparam int FracW   = 16;
  localparam int CfgIdxW = 4;
  localparam int CfgDatW = 32;
  // coef (32 signed) times a 12-bit coordinate widened to 13 signed bits
  localparam int ProdW   = CoefW + CoordW + 1;
  // sum of two products and an offset
  localparam int SumW    = ProdW + 2;
  localparam int WholeW  = SumW - FracW;

  localparam logic [CoordW-1:0] DimLimit = CoordW'(MaxDim - 1);

  typedef logic [CoordW-1:0]       coord_t;
  typedef logic [SpanW-1:0]        span_t;
  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegCoefXx    = 4'd0,
    RegCoefXy    = 4'd1,
    RegCoefX0    = 4'd2,
    RegCoefYx    = 4'd3,
    RegCoefYy    = 4'd4,
    RegCoefY0    = 4'd5,
    RegSrcLastCol = 4'd6,
    RegSrcLastRow = 4'd7
  } reg_idx_t;

  typedef struct packed {
    coord_t col;
    coord_t row;
    span_t  span_begin;
    span_t  span_end;
  } pix_stage_t;

  typedef struct packed {
    prod_t xc;
    prod_t xr;
    prod_t yc;
    prod_t yr;
    logic  outside;
  } prod_stage_t;

  typedef struct packed {
    sum_t sx;
    sum_t sy;
    logic outside;
  } sum_stage_t;

endpackage

/* sv/awna_if.sv */
// awna_if: valid/ready channel interfaces for pixel input, coordinate output
// and register writes. Depends on awna_pkg.
interface awna_pix_if;
  import awna_pkg::*;
  logic   valid;
  logic   ready;
  coord_t dst_col;
  coord_t dst_row;
  span_t  span_begin;
  span_t  span_end;
  modport source (output valid, dst_col, dst_row, span_begin, span_end, input ready);
  modport sink   (input valid, dst_col, dst_row, span_begin, span_end, output ready);
endinterface

interface awna_coord_if;
  import awna_pkg::*;
  logic   valid;
  logic   ready;
  coord_t src_col;
  coord_t src_row;
  logic   outside_span;
  modport source (output valid, src_col, src_row, outside_span, input ready);
  modport sink   (input valid, src_col, src_row, outside_span, output ready);
endinterface

interface awna_cfg_if;
  import awna_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CfgIdxW-1:0]   index;
  logic [CfgDatW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/affine_warp_nearest_address.sv */
// affine_warp_nearest_address: maps destination pixels to nearest source
// pixel coordinates through a Q16.16 inverse affine matrix. Uses awna_pkg, awna_if.
//
//  channel | dir | word                                         | accepted when
//  pixel   | in  | dst_col, dst_row, span_begin, span_end       | valid && ready
//  coord   | out | src_col, src_row, outside_span               | valid && ready
//  cfg     | in  | index, data (register write)                 | valid && ready
//
// Four register stages: input, products, sums, rounded/clamped result.
// One word per clock sustained while coord is ready; coord.valid rises once the word has
// passed the input, product, sum and result registers. Each stage loads when empty or
// when the stage after it moves, so bubbles collapse under an output stall. cfg is always ready.
// rst (synchronous) empties all stages and loads the register reset values.
module affine_warp_nearest_address (
  input  logic              clk,
  input  logic              rst,
  awna_cfg_if.sink          cfg,
  awna_pix_if.sink          pixel,
  awna_coord_if.source      coord
);
  import awna_pkg::*;

  coef_t  coef_xx, coef_xy, coef_x0, coef_yx, coef_yy, coef_y0;
  coord_t src_last_col, src_last_row;

  pix_stage_t  s1;
  prod_stage_t s2;
  sum_stage_t  s3;
  logic        v1, v2, v3, vo;
  logic        rdy1, rdy2, rdy3, rdyo;
  coord_t      res_col, res_row;
  logic        res_outside;
  coord_t      lim_col, lim_row;

  // ---------------- register file ----------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_xx      <= coef_t'(32'sd65536);
      coef_xy      <= '0;
      coef_x0      <= '0;
      coef_yx      <= '0;
      coef_yy      <= coef_t'(32'sd65536);
      coef_y0      <= '0;
      src_last_col <= coord_t'(MaxDim - 1);
      src_last_row <= coord_t'(MaxDim - 1);
    end else if (cfg.valid) begin
      case (cfg.index)
        RegCoefXx:     coef_xx      <= coef_t'(cfg.data);
        RegCoefXy:     coef_xy      <= coef_t'(cfg.data);
        RegCoefX0:     coef_x0      <= coef_t'(cfg.data);
        RegCoefYx:     coef_yx      <= coef_t'(cfg.data);
        RegCoefYy:     coef_yy      <= coef_t'(cfg.data);
        RegCoefY0:     coef_y0      <= coef_t'(cfg.data);
        RegSrcLastCol: src_last_col <= cfg.data[CoordW-1:0];
        RegSrcLastRow: src_last_row <= cfg.data[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage handshakes ----------------
  assign rdyo        = !vo || coord.ready;
  assign rdy3        = !v3 || rdyo;
  assign rdy2        = !v2 || rdy3;
  assign rdy1        = !v1 || rdy2;
  assign pixel.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (rdy1) v1 <= pixel.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdyo) vo <= v3;
    end
  end

  // ---------------- input stage ----------------
  always_ff @(posedge clk) begin
    if (rdy1 && pixel.valid) begin
      s1.col        <= pixel.dst_col;
      s1.row        <= pixel.dst_row;
      s1.span_begin <= pixel.span_begin;
      s1.span_end   <= pixel.span_end;
    end
  end

  // ---------------- product stage ----------------
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2.xc <= ProdW'(coef_xx) * ProdW'($signed({1'b0, s1.col}));
      s2.xr <= ProdW'(coef_xy) * ProdW'($signed({1'b0, s1.row}));
      s2.yc <= ProdW'(coef_yx) * ProdW'($signed({1'b0, s1.col}));
      s2.yr <= ProdW'(coef_yy) * ProdW'($signed({1'b0, s1.row}));
      s2.outside <= ({1'b0, s1.col} < s1.span_begin) || ({1'b0, s1.col} >= s1.span_end);
    end
  end

  // ---------------- sum stage ----------------
  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      s3.sx      <= SumW'(s2.xc) + SumW'(s2.xr) + SumW'(coef_x0);
      s3.sy      <= SumW'(s2.yc) + SumW'(s2.yr) + SumW'(coef_y0);
      s3.outside <= s2.outside;
    end
  end

  // ---------------- round and clamp ----------------
  // Round to nearest, ties to even, then clamp to [0, limit].
  function automatic coord_t round_clamp(input sum_t q, input coord_t limit);
    logic signed [WholeW-1:0] whole;
    logic [FracW-1:0]         frac;
    logic                     up;
    logic signed [WholeW:0]   rnd;
    coord_t                   res;
    whole = q[SumW-1:FracW];
    frac  = q[FracW-1:0];
    up    = (frac > {1'b1, {(FracW-1){1'b0}}}) ||
            ((frac == {1'b1, {(FracW-1){1'b0}}}) && whole[0]);
    rnd   = (WholeW+1)'(whole) + (WholeW+1)'({1'b0, up});
    if (rnd[WholeW]) begin
      res = '0;
    end else if (rnd > (WholeW+1)'({1'b0, limit})) begin
      res = limit;
    end else begin
      res = rnd[CoordW-1:0];
    end
    return res;
  endfunction

  assign lim_col = (src_last_col > DimLimit) ? DimLimit : src_last_col;
  assign lim_row = (src_last_row > DimLimit) ? DimLimit : src_last_row;

  always_comb begin
    res_outside = s3.outside;
    if (s3.outside) begin
      res_col = '0;
      res_row = '0;
    end else begin
      res_col = round_clamp(s3.sx, lim_col);
      res_row = round_clamp(s3.sy, lim_row);
    end
  end

  always_ff @(posedge clk) begin
    if (rdyo && v3) begin
      coord.src_col      <= res_col;
      coord.src_row      <= res_row;
      coord.outside_span <= res_outside;
    end
  end

  assign coord.valid = vo;

  // ---------------- assertions ----------------
  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    (coord.valid && coord.outside_span) |-> (coord.src_col == '0 && coord.src_row == '0))
    else $error("border word carries nonzero coordinates");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> (v1 && v2 && v3 && vo))
    else $error("input stalled with a bubble in the pipeline");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.ready) |=> v1)
    else $error("accepted word not held in input stage");

  a_out_from_sum: assert property (@(posedge clk) disable iff (rst)
    $rose(coord.valid) |-> $past(v3))
    else $error("result appeared without a word in the sum stage");

endmodule

/* bench/affine_warp_nearest_address_tb.sv */
// affine_warp_nearest_address_tb: drives pixel words and register writes into
// the affine warp address block and checks every coord word against a typed expected
// word or a local fixed-point predictor. Depends on awna_pkg, the awna_*_if interfaces and the RTL.
module affine_warp_nearest_address_tb;
  import awna_pkg::*;

  localparam int IdlePct       = 23;
  localparam int LongHold      = 300;
  localparam int PipeCycles    = 4;
  localparam int DrainLimit    = 5000;
  localparam int TimeoutCycles = 200000;
  localparam int RandPhases    = 12;
  localparam int PhaseItems    = 136;
  localparam int DirRows       = 21;

  localparam coef_t QOne = coef_t'(1 << FracW);
  localparam logic [FracW-1:0] QHalf = FracW'(1 << (FracW - 1));

  typedef enum logic [2:0] {
    SetIdentity,
    SetHalf,
    SetMax,
    SetMin,
    SetNear,
    SetWild
  } warp_kind_t;

  typedef struct packed {
    coord_t col;
    coord_t row;
    span_t  span_begin;
    span_t  span_end;
  } pixel_word_t;

  typedef struct packed {
    coord_t col;
    coord_t row;
    logic   outside;
  } src_word_t;

  typedef struct {
    coef_t  coef[6];
    coord_t last_col;
    coord_t last_row;
  } warp_setting_t;

  typedef struct packed {
    warp_kind_t  kind;
    pixel_word_t pix;
    logic        typed;
    src_word_t   want;
  } directed_row_t;

  // typed rows: identity matrix after reset, and the half-step matrix where
  // ties, negative clamp and upper clamp can be read off directly
  localparam directed_row_t Plan [DirRows] = '{
    '{SetIdentity, '{12'd0,    12'd0,    13'd0,    13'd4096}, 1'b1, '{12'd0,    12'd0,    1'b0}},
    '{SetIdentity, '{12'd4095, 12'd4095, 13'd0,    13'd4096}, 1'b1, '{12'd4095, 12'd4095, 1'b0}},
    '{SetIdentity, '{12'd100,  12'd7,    13'd101,  13'd200},  1'b1, '{12'd0,    12'd0,    1'b1}},
    '{SetIdentity, '{12'd200,  12'd7,    13'd101,  13'd200},  1'b1, '{12'd0,    12'd0,    1'b1}},
    '{SetIdentity, '{12'd101,  12'd7,    13'd101,  13'd200},  1'b1, '{12'd101,  12'd7,    1'b0}},
    '{SetIdentity, '{12'd199,  12'd3000, 13'd101,  13'd200},  1'b1, '{12'd199,  12'd3000, 1'b0}},
    '{SetIdentity, '{12'd50,   12'd9,    13'd300,  13'd300},  1'b1, '{12'd0,    12'd0,    1'b1}},
    '{SetIdentity, '{12'd50,   12'd9,    13'd4096, 13'd0},    1'b1, '{12'd0,    12'd0,    1'b1}},
    '{SetIdentity, '{12'd4095, 12'd0,    13'd4095, 13'd4096}, 1'b1, '{12'd4095, 12'd0,    1'b0}},
    '{SetIdentity, '{12'd2730, 12'd1365, 13'd0,    13'd4096}, 1'b1, '{12'd2730, 12'd1365, 1'b0}},
    '{SetIdentity, '{12'd0,    12'd4095, 13'd1,    13'd4096}, 1'b1, '{12'd0,    12'd0,    1'b1}},
    '{SetHalf,     '{12'd1,    12'd2,    13'd0,    13'd4096}, 1'b1, '{12'd0,    12'd8,    1'b0}},
    '{SetHalf,     '{12'd3,    12'd3,    13'd0,    13'd4096}, 1'b1, '{12'd2,    12'd8,    1'b0}},
    '{SetHalf,     '{12'd5,    12'd0,    13'd0,    13'd4096}, 1'b1, '{12'd2,    12'd9,    1'b0}},
    '{SetHalf,     '{12'd4095, 12'd20,   13'd0,    13'd4096}, 1'b1, '{12'd1000, 12'd0,    1'b0}},
    '{SetHalf,     '{12'd2,    12'd4095, 13'd0,    13'd4096}, 1'b1, '{12'd1,    12'd0,    1'b0}},
    '{SetHalf,     '{12'd7,    12'd0,    13'd8,    13'd9},    1'b1, '{12'd0,    12'd0,    1'b1}},
    '{SetMax,      '{12'd0,    12'd0,    13'd0,    13'd4096}, 1'b0, '{12'd0,    12'd0,    1'b0}},
    '{SetMax,      '{12'd4095, 12'd4095, 13'd0,    13'd4096}, 1'b0, '{12'd0,    12'd0,    1'b0}},
    '{SetMin,      '{12'd0,    12'd0,    13'd0,    13'd4096}, 1'b0, '{12'd0,    12'd0,    1'b0}},
    '{SetMin,      '{12'd4095, 12'd4095, 13'd0,    13'd4096}, 1'b0, '{12'd0,    12'd0,    1'b0}}
  };

  localparam warp_kind_t PhaseKinds [RandPhases] = '{
    SetNear, SetWild, SetNear, SetMax, SetNear, SetMin,
    SetNear, SetWild, SetIdentity, SetNear, SetWild, SetNear
  };

  logic clk = 1'b0;
  logic rst;

  awna_cfg_if   cfg_bus ();
  awna_pix_if   pix_bus ();
  awna_coord_if coord_bus ();

  affine_warp_nearest_address u_dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_bus),
    .pixel (pix_bus),
    .coord (coord_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  warp_setting_t live;
  src_word_t     expected_coords[$];
  int            mismatches = 0;
  int            hold_reqs = 0;
  bit            idle_on = 1'b1;

  function automatic coef_t jitter(input int unsigned span);
    return coef_t'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  function automatic coord_t random_limit();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? DimLimit : '0;
    return coord_t'($urandom_range(0, MaxDim - 1));
  endfunction

  function automatic warp_setting_t make_setting(input warp_kind_t kind);
    warp_setting_t s;
    s.coef = '{QOne, 0, 0, 0, QOne, 0};
    s.last_col = DimLimit;
    s.last_row = DimLimit;
    case (kind)
      SetHalf: begin
        s.coef = '{32'sh0000_8000, 0, 0, 0, 32'shFFFF_0000, 32'sh000A_8000};
        s.last_col = 12'd1000;
        s.last_row = 12'd9;
      end
      SetMax: s.coef = '{6{32'sh7FFF_FFFF}};
      SetMin: begin
        s.coef = '{6{32'sh8000_0000}};
        s.last_col = '0;
        s.last_row = '0;
      end
      SetNear: begin
        // mild scale/shear around identity so most words land inside the source
        s.coef[0] = QOne + jitter(24000);
        s.coef[1] = jitter(24000);
        s.coef[2] = jitter(512 << FracW);
        s.coef[3] = jitter(24000);
        s.coef[4] = QOne + jitter(24000);
        s.coef[5] = jitter(512 << FracW);
        s.last_col = random_limit();
        s.last_row = random_limit();
      end
      SetWild: begin
        foreach (s.coef[k]) s.coef[k] = coef_t'($urandom());
        s.last_col = random_limit();
        s.last_row = random_limit();
      end
      default: ;
    endcase
    return s;
  endfunction

  // round half to even, then clamp to [0, last]
  function automatic coord_t nearest_clamped(input longint q, input coord_t last);
    longint           whole;
    logic [FracW-1:0] frac;
    whole = q >>> FracW;
    frac = q[FracW-1:0];
    if (frac > QHalf || (frac == QHalf && (whole & 1) != 0)) whole++;
    if (whole < 0) return '0;
    if (whole > longint'(last)) return last;
    return coord_t'(whole);
  endfunction

  function automatic src_word_t warp_to_source(input pixel_word_t p);
    src_word_t r;
    longint    c;
    longint    w;
    longint    sx;
    longint    sy;
    r = '0;
    if (p.col < p.span_begin || p.col >= p.span_end) begin
      r.outside = 1'b1;
      return r;
    end
    c = longint'(p.col);
    w = longint'(p.row);
    sx = longint'(live.coef[0]) * c + longint'(live.coef[1]) * w + longint'(live.coef[2]);
    sy = longint'(live.coef[3]) * c + longint'(live.coef[4]) * w + longint'(live.coef[5]);
    r.col = nearest_clamped(sx, live.last_col);
    r.row = nearest_clamped(sy, live.last_row);
    return r;
  endfunction

  function automatic pixel_word_t random_pixel();
    pixel_word_t p;
    span_t       lo;
    int unsigned pick;
    p.row = coord_t'($urandom_range(0, MaxDim - 1));
    p.col = coord_t'($urandom_range(0, MaxDim - 1));
    p.span_begin = span_t'($urandom_range(0, MaxDim));
    p.span_end = span_t'($urandom_range(0, MaxDim));
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      // ordered span, column mostly inside or on its edges
      if (p.span_end < p.span_begin) begin
        lo = p.span_end;
        p.span_end = p.span_begin;
        p.span_begin = lo;
      end
      if (pick < 8) p.col = coord_t'(p.span_begin);
      else if (pick < 16) p.col = coord_t'(p.span_end - 1);
      else if (pick < 22) p.col = coord_t'(p.span_end);
      else if (p.span_begin < p.span_end)
        p.col = coord_t'($urandom_range(p.span_begin, p.span_end - 1));
    end
    return p;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx < CfgIdxW'(RegSrcLastCol)) live.coef[idx] = coef_t'(val);
    else if (idx == CfgIdxW'(RegSrcLastCol)) live.last_col = val[CoordW-1:0];
    else if (idx == CfgIdxW'(RegSrcLastRow)) live.last_row = val[CoordW-1:0];
  endtask

  task automatic drain_results();
    int waited;
    pix_bus.valid <= 1'b0;
    waited = 0;
    while (expected_coords.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (expected_coords.size() != 0) begin
      $display("%0t: %0d coord words never arrived", $time, expected_coords.size());
      mismatches++;
      expected_coords.delete();
    end
    repeat (PipeCycles) @(posedge clk);
  endtask

  task automatic change_setting(input warp_kind_t kind);
    warp_setting_t s;
    s = make_setting(kind);
    drain_results();
    // write past the register list; must leave everything untouched
    write_reg(CfgIdxW'(RegSrcLastRow) + CfgIdxW'($urandom_range(1, 8)), $urandom());
    foreach (s.coef[k]) write_reg(CfgIdxW'(RegCoefXx) + CfgIdxW'(k), s.coef[k]);
    write_reg(RegSrcLastCol, {20'($urandom()), s.last_col});
    write_reg(RegSrcLastRow, {20'($urandom()), s.last_row});
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_pixel(input pixel_word_t p, input src_word_t want);
    while (idle_on && $urandom_range(0, 99) < IdlePct) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pix_bus.valid      <= 1'b1;
    pix_bus.dst_col    <= p.col;
    pix_bus.dst_row    <= p.row;
    pix_bus.span_begin <= p.span_begin;
    pix_bus.span_end   <= p.span_end;
    @(posedge clk);
    while (!pix_bus.ready) @(posedge clk);
    expected_coords.push_back(want);
  endtask

  // coord sink: random backpressure, long hold-offs on request, word checks
  initial begin : coord_sink
    src_word_t want;
    int        hold_left;
    int        holds_done;
    hold_left = 0;
    holds_done = 0;
    coord_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && coord_bus.valid && coord_bus.ready) begin
        if (expected_coords.size() == 0) begin
          $display("%0t: unexpected coord word col=%0d row=%0d outside=%0b", $time,
                   coord_bus.src_col, coord_bus.src_row, coord_bus.outside_span);
          mismatches++;
        end else begin
          want = expected_coords.pop_front();
          if (coord_bus.src_col !== want.col) begin
            $display("%0t: src_col expected %0d got %0d", $time, want.col, coord_bus.src_col);
            mismatches++;
          end
          if (coord_bus.src_row !== want.row) begin
            $display("%0t: src_row expected %0d got %0d", $time, want.row, coord_bus.src_row);
            mismatches++;
          end
          if (coord_bus.outside_span !== want.outside) begin
            $display("%0t: outside_span expected %0b got %0b", $time, want.outside,
                     coord_bus.outside_span);
            mismatches++;
          end
        end
      end
      if (holds_done != hold_reqs) begin
        holds_done = hold_reqs;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        coord_bus.ready <= 1'b0;
      end else begin
        coord_bus.ready <= !idle_on || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  initial begin : stimulus
    warp_kind_t  current;
    pixel_word_t p;
    live = make_setting(SetIdentity);
    current = SetIdentity;
    rst                <= 1'b1;
    pix_bus.valid      <= 1'b0;
    pix_bus.dst_col    <= '0;
    pix_bus.dst_row    <= '0;
    pix_bus.span_begin <= '0;
    pix_bus.span_end   <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= '0;
    cfg_bus.data       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (Plan[n]) begin
      if (Plan[n].kind != current) begin
        change_setting(Plan[n].kind);
        current = Plan[n].kind;
      end
      send_pixel(Plan[n].pix, Plan[n].typed ? Plan[n].want : warp_to_source(Plan[n].pix));
    end

    for (int ph = 0; ph < RandPhases; ph++) begin
      change_setting(PhaseKinds[ph]);
      idle_on = (ph != 4);
      for (int i = 0; i < PhaseItems; i++) begin
        // stall the output long enough to back the pipe up into the input
        if (ph == 2 && i == 40) hold_reqs++;
        if (ph == 6 && i == 60) drain_results();
        p = random_pixel();
        send_pixel(p, warp_to_source(p));
      end
    end

    drain_results();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin : watchdog
    #(8 * TimeoutCycles);
    $display("FAILURE");
    $finish;
  end

endmodule
